### hdl/asm_pkg.sv
// ----------------------------------------------------------------------------
// asm_pkg
// Shared widths, request and status codes for the alarm slot multiplexer.
// ----------------------------------------------------------------------------
package asm_pkg;

	localparam int TIME_W   = 32;
	localparam int REQ_W    = 2;
	localparam int HANDLE_W = 8;
	localparam int SLOT_W   = 4;
	localparam int STATUS_W = 2;

	// largest slot count the handle fields can carry
	localparam int MAX_SLOTS     = 16;
	localparam int DEF_NUM_SLOTS = 16;

	// alarm time that is stored but never selected
	localparam logic [TIME_W-1:0] NEVER_TIME = 32'hFFFF_FFFF;

	typedef enum logic [REQ_W-1:0] {
		REQ_SET    = 2'd0,
		REQ_CANCEL = 2'd1,
		REQ_TICK   = 2'd2
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK   = 2'd0,
		STATUS_PAST = 2'd1,
		STATUS_FULL = 2'd2
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic decide;
		logic scan_step;
		logic commit;
		logic load_out;
	} asm_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_sel;
		logic scan_last;
		logic out_free;
	} asm_sts_t;

endpackage

### hdl/asm_req_if.sv
// ----------------------------------------------------------------------------
// asm_req_if
// Request channel: valid/ready handshake with one request per beat.
// ----------------------------------------------------------------------------
interface asm_req_if;
	import asm_pkg::*;

	logic                valid;
	logic                ready;
	logic [REQ_W-1:0]    req_type;
	logic [TIME_W-1:0]   alarm_time;
	logic [HANDLE_W-1:0] cancel_handle;
	logic [TIME_W-1:0]   current_time;

	modport source (
		output valid, req_type, alarm_time, cancel_handle, current_time,
		input  ready
	);

	modport sink (
		input  valid, req_type, alarm_time, cancel_handle, current_time,
		output ready
	);

endinterface

### hdl/asm_rsp_if.sv
// ----------------------------------------------------------------------------
// asm_rsp_if
// Response channel: valid/ready handshake with one result per beat.
// ----------------------------------------------------------------------------
interface asm_rsp_if;
	import asm_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0]   slot_handle;
	logic                fired;
	logic                active_valid;
	logic [SLOT_W-1:0]   active_handle;
	logic [TIME_W-1:0]   active_time;
	logic [TIME_W-1:0]   remaining;

	modport source (
		output valid, status, slot_handle, fired, active_valid, active_handle,
		       active_time, remaining,
		input  ready
	);

	modport sink (
		input  valid, status, slot_handle, fired, active_valid, active_handle,
		       active_time, remaining,
		output ready
	);

endinterface

### hdl/asm_ctrl.sv
// ----------------------------------------------------------------------------
// asm_ctrl
// Sequencer: capture, decide, scan of the slot table, drain, commit, result load.
// ----------------------------------------------------------------------------
module asm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output asm_pkg::asm_cmd_t cmd,
	input  asm_pkg::asm_sts_t sts
);
	import asm_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_SCAN,
		S_DRAIN,
		S_COMMIT,
		S_DONE
	} state_t;

	state_t state_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					state_q <= sts.need_sel ? S_SCAN : S_DONE;
				end
				S_SCAN: begin
					if (sts.scan_last) state_q <= S_DRAIN;
				end
				S_DRAIN: begin
					state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (sts.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// commands decoded from state
	always_comb begin
		in_ready      = (state_q == S_IDLE);
		cmd.capture   = (state_q == S_IDLE) && in_valid;
		cmd.decide    = (state_q == S_DECIDE);
		cmd.scan_step = (state_q == S_SCAN);
		cmd.commit    = (state_q == S_COMMIT);
		cmd.load_out  = (state_q == S_DONE) && sts.out_free;
	end

endmodule

### hdl/asm_datapath.sv
// ----------------------------------------------------------------------------
// asm_datapath
// Slot table, occupancy, active alarm registers, earliest-slot scan and the
// result register.
// ----------------------------------------------------------------------------
module asm_datapath #(
	parameter int NUM_SLOTS = asm_pkg::DEF_NUM_SLOTS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  asm_pkg::asm_cmd_t             cmd,
	output asm_pkg::asm_sts_t             sts,
	input  logic [asm_pkg::REQ_W-1:0]     in_req_type,
	input  logic [asm_pkg::TIME_W-1:0]    in_alarm_time,
	input  logic [asm_pkg::HANDLE_W-1:0]  in_cancel_handle,
	input  logic [asm_pkg::TIME_W-1:0]    in_current_time,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [asm_pkg::STATUS_W-1:0]  out_status,
	output logic [asm_pkg::SLOT_W-1:0]    out_slot_handle,
	output logic                          out_fired,
	output logic                          out_active_valid,
	output logic [asm_pkg::SLOT_W-1:0]    out_active_handle,
	output logic [asm_pkg::TIME_W-1:0]    out_active_time,
	output logic [asm_pkg::TIME_W-1:0]    out_remaining
);
	import asm_pkg::*;

	localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam logic [HANDLE_W-1:0] HANDLE_LIMIT = HANDLE_W'(NUM_SLOTS);
	localparam logic [IDX_W-1:0]    LAST_IDX     = IDX_W'(NUM_SLOTS - 1);

	// captured request
	logic [REQ_W-1:0]    req_q;
	logic [TIME_W-1:0]   atime_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [TIME_W-1:0]   now_q;

	// table and active alarm
	logic [TIME_W-1:0]    mem [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] occ_q;
	logic                 act_vld_q;
	logic [IDX_W-1:0]     act_slot_q;
	logic [TIME_W-1:0]    cmp_q;

	// scan state
	logic [IDX_W-1:0]  idx_q;
	logic              vld_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [TIME_W-1:0] rd_data_s1;
	logic [TIME_W-1:0] best_q;
	logic [IDX_W-1:0]  pick_q;
	logic              found_q;

	// per-request result
	logic [STATUS_W-1:0] res_status_q;
	logic [SLOT_W-1:0]   res_slot_q;
	logic                res_fired_q;
	logic                out_vld_q;

	// lowest free slot
	logic             free_found;
	logic [IDX_W-1:0] free_idx;

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (!occ_q[i]) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(i);
			end
		end
	end

	// request decode
	logic [STATUS_W-1:0]  d_status;
	logic [SLOT_W-1:0]    d_slot;
	logic                 d_fired;
	logic                 d_need_sel;
	logic                 d_wr_en;
	logic [NUM_SLOTS-1:0] d_occ;

	always_comb begin
		d_status   = STATUS_OK;
		d_slot     = '0;
		d_fired    = 1'b0;
		d_need_sel = 1'b0;
		d_wr_en    = 1'b0;
		d_occ      = occ_q;
		unique case (req_q)
			REQ_SET: begin
				if (!(now_q < atime_q)) begin
					d_status = STATUS_PAST;
				end else if (!free_found) begin
					d_status = STATUS_FULL;
				end else begin
					d_wr_en         = 1'b1;
					d_occ[free_idx] = 1'b1;
					d_slot          = SLOT_W'(free_idx);
					d_need_sel      = 1'b1;
				end
			end
			REQ_CANCEL: begin
				if (handle_q < HANDLE_LIMIT) begin
					d_occ[handle_q[IDX_W-1:0]] = 1'b0;
					d_need_sel                 = 1'b1;
				end
			end
			REQ_TICK: begin
				if (act_vld_q && (now_q >= cmp_q)) begin
					d_fired           = 1'b1;
					d_slot            = SLOT_W'(act_slot_q);
					d_occ[act_slot_q] = 1'b0;
					d_need_sel        = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// scan compare on registered read data
	logic take;
	assign take = vld_s1 && occ_q[idx_s1] && (rd_data_s1 < best_q);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q      <= '0;
			act_vld_q  <= 1'b0;
			act_slot_q <= '0;
			cmp_q      <= '0;
			vld_s1     <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (cmd.decide) occ_q <= d_occ;
			if (cmd.commit) begin
				act_vld_q  <= found_q;
				act_slot_q <= found_q ? pick_q : '0;
				cmp_q      <= found_q ? best_q : '0;
			end
			vld_s1 <= cmd.scan_step;
			if (cmd.load_out) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// slot table write and scan read
	always_ff @(posedge clk) begin
		if (cmd.decide && d_wr_en) mem[free_idx] <= atime_q;
		if (cmd.scan_step) rd_data_s1 <= mem[idx_q];
	end

	// request capture, scan counters and result payload
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q    <= in_req_type;
			atime_q  <= in_alarm_time;
			handle_q <= in_cancel_handle;
			now_q    <= in_current_time;
		end
		if (cmd.decide) begin
			res_status_q <= d_status;
			res_slot_q   <= d_slot;
			res_fired_q  <= d_fired;
			idx_q        <= '0;
			best_q       <= NEVER_TIME;
			pick_q       <= '0;
			found_q      <= 1'b0;
		end else begin
			if (cmd.scan_step) begin
				idx_q  <= idx_q + IDX_W'(1);
				idx_s1 <= idx_q;
			end
			if (take) begin
				best_q  <= rd_data_s1;
				pick_q  <= idx_s1;
				found_q <= 1'b1;
			end
		end
		if (cmd.load_out) begin
			out_status        <= res_status_q;
			out_slot_handle   <= res_slot_q;
			out_fired         <= res_fired_q;
			out_active_valid  <= act_vld_q;
			out_active_handle <= act_vld_q ? SLOT_W'(act_slot_q) : '0;
			out_active_time   <= act_vld_q ? cmp_q : '0;
			out_remaining     <= act_vld_q ? (cmp_q - now_q) : '0;
		end
	end

	assign out_valid = out_vld_q;

	// status to controller
	always_comb begin
		sts.need_sel  = d_need_sel;
		sts.scan_last = (idx_q == LAST_IDX);
		sts.out_free  = !out_vld_q || out_ready;
	end

endmodule

### hdl/alarm_slot_multiplexer_core.sv
// ----------------------------------------------------------------------------
// alarm_slot_multiplexer_core
// Table of alarm slots multiplexed onto one seconds compare value.
// ----------------------------------------------------------------------------
// Each request (set, cancel or tick) yields exactly one result carrying the
// request status, the slot it touched and the now-active alarm with its
// remaining seconds. A set that lands in a slot, a cancel with an in-range
// handle (even of a free slot) and a tick that fires go through the
// earliest-slot reselect, which reads the slot table one entry per cycle
// through its single read port; every other request skips the reselect.
// One request is in work at a time; the result register lets the next
// request be accepted while the previous result still waits on the
// response channel.
module alarm_slot_multiplexer_core #(
	parameter int NUM_SLOTS = asm_pkg::DEF_NUM_SLOTS
) (
	input  logic      clk,
	input  logic      arst_n,
	asm_req_if.sink   req,
	asm_rsp_if.source rsp
);
	import asm_pkg::*;

	asm_cmd_t cmd;
	asm_sts_t sts;

	// sequencer
	asm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// slot table and result path
	asm_datapath #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.in_req_type       (req.req_type),
		.in_alarm_time     (req.alarm_time),
		.in_cancel_handle  (req.cancel_handle),
		.in_current_time   (req.current_time),
		.out_valid         (rsp.valid),
		.out_ready         (rsp.ready),
		.out_status        (rsp.status),
		.out_slot_handle   (rsp.slot_handle),
		.out_fired         (rsp.fired),
		.out_active_valid  (rsp.active_valid),
		.out_active_handle (rsp.active_handle),
		.out_active_time   (rsp.active_time),
		.out_remaining     (rsp.remaining)
	);

endmodule
